@@ sv/brf_pkg.sv @@
package brf_pkg;

  // Default sizes of the store and of the longest read burst.
  localparam int unsigned DEPTH_DEF     = 1024;
  localparam int unsigned MAX_BURST_DEF = 64;

  // Stream word widths at the block boundary.
  localparam int unsigned S_DATA_W = 16;
  localparam int unsigned S_USER_W = 2;
  localparam int unsigned M_DATA_W = 24;
  localparam int unsigned M_USER_W = 3;

  // Field widths.
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned LEVEL_W = 10;

  // Request kinds carried on the input tuser.
  localparam logic [S_USER_W-1:0] REQ_ENQ   = 2'd0;
  localparam logic [S_USER_W-1:0] REQ_DEQ   = 2'd1;
  localparam logic [S_USER_W-1:0] REQ_PEEK  = 2'd2;
  localparam logic [S_USER_W-1:0] REQ_CLEAR = 2'd3;

  // Result status codes carried on the output tuser.
  localparam logic [M_USER_W-1:0] STAT_ACCEPTED = 3'd0;
  localparam logic [M_USER_W-1:0] STAT_DROPPED  = 3'd1;
  localparam logic [M_USER_W-1:0] STAT_READ     = 3'd2;
  localparam logic [M_USER_W-1:0] STAT_NOTHING  = 3'd3;
  localparam logic [M_USER_W-1:0] STAT_CLEARED  = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // take the request on the input stream this cycle
    logic busy;    // a read burst is in progress
    logic send;    // load the next burst byte into the output register
  } brf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;   // output register can take a new result
    logic burst;      // the request on the input is a read of one byte or more
    logic last_byte;  // the byte being sent ends the burst
  } brf_sts_t;

endpackage

@@ sv/brf_ram.sv @@
module brf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/brf_ctrl.sv @@
module brf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  brf_pkg::brf_sts_t sts,
  output brf_pkg::brf_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SEND = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  // Requests are taken only between bursts and when the result has a place to go.
  always_comb begin
    s_tready   = (state == ST_IDLE) && sts.out_free;
    cmd.accept = s_tready && s_tvalid;
    cmd.busy   = (state == ST_SEND);
    cmd.send   = cmd.busy && sts.out_free;
  end

  // Next state: a read of one byte or more streams its bytes out in the send state.
  always_comb begin
    case (state)
      ST_IDLE: begin
        state_next = (cmd.accept && sts.burst) ? ST_SEND : ST_IDLE;
      end
      ST_SEND: begin
        state_next = (cmd.send && sts.last_byte) ? ST_IDLE : ST_SEND;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ sv/brf_dp.sv @@
module brf_dp #(
  parameter int unsigned DEPTH     = brf_pkg::DEPTH_DEF,
  parameter int unsigned MAX_BURST = brf_pkg::MAX_BURST_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [brf_pkg::S_DATA_W-1:0]  s_tdata,
  input  logic [brf_pkg::S_USER_W-1:0]  s_tuser,
  input  brf_pkg::brf_cmd_t             cmd,
  output brf_pkg::brf_sts_t             sts,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [brf_pkg::M_DATA_W-1:0]  m_tdata,
  output logic [brf_pkg::M_USER_W-1:0]  m_tuser,
  output logic                          m_tlast
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(MAX_BURST + 1);
  localparam int unsigned MW = (AW > brf_pkg::COUNT_W) ? AW : brf_pkg::COUNT_W;
  localparam int unsigned PAD_W = brf_pkg::M_DATA_W - brf_pkg::LEVEL_W - brf_pkg::BYTE_W;

  logic [brf_pkg::S_USER_W-1:0] req;
  logic [brf_pkg::BYTE_W-1:0]   din;
  logic [brf_pkg::COUNT_W-1:0]  cnt_in;
  logic [brf_pkg::COUNT_W-1:0]  cap;
  logic [MW-1:0]                take;
  logic [CW-1:0]                n;
  logic                         full;
  logic                         is_rd;
  logic                         load;

  // Ring indices, fill count and burst bookkeeping.
  logic [AW-1:0] rd_idx;
  logic [AW-1:0] wr_idx;
  logic [AW-1:0] fill;
  logic [AW-1:0] cur;
  logic [AW-1:0] cur_inc;
  logic [CW-1:0] remain;
  logic          consume;

  // Byte store ports.
  logic                       we;
  logic [AW-1:0]              raddr;
  logic [brf_pkg::BYTE_W-1:0] rdata;

  // Output register and its next value.
  logic [brf_pkg::BYTE_W-1:0]   out_data;
  logic [brf_pkg::M_USER_W-1:0] out_stat;
  logic                         out_last;
  logic [AW-1:0]                out_fill;
  logic [brf_pkg::BYTE_W-1:0]   out_data_next;
  logic [brf_pkg::M_USER_W-1:0] out_stat_next;
  logic                         out_last_next;
  logic [AW-1:0]                out_fill_next;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] i);
    return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  // Split the request and size the burst as min(count, MAX_BURST, fill).
  always_comb begin
    req    = s_tuser;
    din    = s_tdata[brf_pkg::BYTE_W-1:0];
    cnt_in = s_tdata[brf_pkg::BYTE_W +: brf_pkg::COUNT_W];
    cap    = (cnt_in > brf_pkg::COUNT_W'(MAX_BURST)) ? brf_pkg::COUNT_W'(MAX_BURST) : cnt_in;
    take   = (MW'(cap) > MW'(fill)) ? MW'(fill) : MW'(cap);
    n      = CW'(take);
    full   = (fill == AW'(DEPTH - 1));
    is_rd  = (req == brf_pkg::REQ_DEQ) || (req == brf_pkg::REQ_PEEK);
  end

  // Status back to the controller.
  always_comb begin
    sts.out_free  = !m_tvalid || m_tready;
    sts.burst     = is_rd && (n != '0);
    sts.last_byte = (remain == CW'(1));
  end

  // The read address steps ahead as each byte leaves, so a burst streams
  // one byte per cycle unless stalled; idle, it points at the oldest byte.
  always_comb begin
    cur_inc = wrap_inc(cur);
    we      = cmd.accept && (req == brf_pkg::REQ_ENQ) && !full;
    if (cmd.send) begin
      raddr = cur_inc;
    end else if (cmd.busy) begin
      raddr = cur;
    end else begin
      raddr = rd_idx;
    end
  end

  brf_ram #(
    .WIDTH (brf_pkg::BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (wr_idx),
    .wdata (din),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Result for the next load of the output register.
  always_comb begin
    load          = cmd.send || (cmd.accept && !sts.burst);
    out_data_next = '0;
    out_last_next = 1'b1;
    out_stat_next = brf_pkg::STAT_NOTHING;
    out_fill_next = fill;
    if (cmd.send) begin
      out_data_next = rdata;
      out_stat_next = brf_pkg::STAT_READ;
      out_last_next = sts.last_byte;
      out_fill_next = consume ? fill - 1'b1 : fill;
    end else begin
      case (req)
        brf_pkg::REQ_ENQ: begin
          out_stat_next = full ? brf_pkg::STAT_DROPPED : brf_pkg::STAT_ACCEPTED;
          out_fill_next = full ? fill : fill + 1'b1;
        end
        brf_pkg::REQ_CLEAR: begin
          out_stat_next = brf_pkg::STAT_CLEARED;
          out_fill_next = '0;
        end
        default: begin
          out_stat_next = brf_pkg::STAT_NOTHING;
        end
      endcase
    end
  end

  // Ring state and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx   <= '0;
      wr_idx   <= '0;
      fill     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.accept) begin
        case (req)
          brf_pkg::REQ_ENQ: begin
            if (!full) begin
              wr_idx <= wrap_inc(wr_idx);
              fill   <= fill + 1'b1;
            end
          end
          brf_pkg::REQ_CLEAR: begin
            rd_idx <= '0;
            wr_idx <= '0;
            fill   <= '0;
          end
          default: begin
          end
        endcase
      end
      if (cmd.send && consume) begin
        rd_idx <= cur_inc;
        fill   <= fill - 1'b1;
      end
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Burst cursor and output payload.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur     <= rd_idx;
      remain  <= n;
      consume <= (req == brf_pkg::REQ_DEQ);
    end
    if (cmd.send) begin
      cur    <= cur_inc;
      remain <= remain - 1'b1;
    end
    if (load) begin
      out_data <= out_data_next;
      out_stat <= out_stat_next;
      out_last <= out_last_next;
      out_fill <= out_fill_next;
    end
  end

  assign m_tdata = {PAD_W'(0), brf_pkg::LEVEL_W'(out_fill), out_data};
  assign m_tuser = out_stat;
  assign m_tlast = out_last;

endmodule

@@ sv/byte_ring_fifo_with_peek.sv @@
// Channel   Dir  tdata (low bit up)                      tuser         tlast
// s_*       in   data_byte[7:0], byte_count[14:8], 0     req_type[1:0] run_last
// m_*       out  data_out[7:0], fill_level[17:8], 0s     status[2:0]   result_last
//
// Enqueue, clear and empty or zero-count reads give one result per request.
// A dequeue or peek of n bytes holds the input while, after the accept, its
// bytes leave one per unstalled cycle from the store's registered read port.
// Synchronous reset empties the ring; the store contents are not cleared.
// A stalled output holds the result and the input waits; run_last has no effect.
module byte_ring_fifo_with_peek #(
  parameter int unsigned DEPTH     = brf_pkg::DEPTH_DEF,
  parameter int unsigned MAX_BURST = brf_pkg::MAX_BURST_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [brf_pkg::S_DATA_W-1:0] s_tdata,  // data_byte, byte_count, pad
  input  logic [brf_pkg::S_USER_W-1:0] s_tuser,  // req_type
  input  logic                         s_tlast,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [brf_pkg::M_DATA_W-1:0] m_tdata,  // data_out, fill_level, pad
  output logic [brf_pkg::M_USER_W-1:0] m_tuser,  // status
  output logic                         m_tlast
);

  brf_pkg::brf_cmd_t cmd;
  brf_pkg::brf_sts_t sts;

  brf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  brf_dp #(
    .DEPTH     (DEPTH),
    .MAX_BURST (MAX_BURST)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

@@ sv/brf_checker.sv @@
module brf_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic [brf_pkg::S_DATA_W-1:0] s_tdata,
  input logic [brf_pkg::S_USER_W-1:0] s_tuser,
  input logic                         s_tlast,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [brf_pkg::M_DATA_W-1:0] m_tdata,
  input logic [brf_pkg::M_USER_W-1:0] m_tuser,
  input logic                         m_tlast
);

  // A stalled result keeps its payload.
  a_hold : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result changed");

  // A clear request answers next cycle with a cleared result and an empty level.
  a_clear : assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == brf_pkg::REQ_CLEAR) |=>
      m_tvalid && (m_tuser == brf_pkg::STAT_CLEARED) && m_tlast && (m_tdata[17:8] == 10'd0))
    else $error("clear result missing");

  // An enqueue answers next cycle with a single accepted or dropped result.
  a_enq : assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == brf_pkg::REQ_ENQ) |=>
      m_tvalid && m_tlast && ((m_tuser == brf_pkg::STAT_ACCEPTED) ||
      (m_tuser == brf_pkg::STAT_DROPPED)))
    else $error("enqueue result missing");

  // Only byte reads carry data or leave a request open.
  a_nonread : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != brf_pkg::STAT_READ) |-> m_tlast && (m_tdata[7:0] == 8'd0))
    else $error("non-read result with data or open end");

  // While a burst is still open the input is not taken.
  a_burst : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == brf_pkg::STAT_READ) && !m_tlast |-> !s_tready)
    else $error("request taken inside a burst");

endmodule

bind byte_ring_fifo_with_peek brf_checker u_brf_checker (.*);
